// ===== hw/rtl/binary_search_sorted_table_assert.svh =====
// Assertion macros shared by the binary search block.
`ifndef BINARY_SEARCH_SORTED_TABLE_ASSERT_SVH
`define BINARY_SEARCH_SORTED_TABLE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define BSST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define BSST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bsst_pkg.sv =====
// Package: sizes, codes and types of the binary search block.
package bsst_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int LEN_W       = IDX_W + 1;
	localparam int PTR_W       = IDX_W + 2;
	localparam int DATA_W      = 32;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	localparam logic signed [PTR_W-1:0] PTR_ONE = PTR_W'(1);
	localparam logic [LEN_W-1:0]        LEN_MAX = LEN_W'(TABLE_DEPTH);

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		data_t wdata;
		logic  re;
		idx_t  raddr;
	} bsst_ram_req_t;

endpackage

// ===== hw/rtl/bsst_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bsst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bsst_ctrl.sv =====
// Request sequencer: table loads, probe loop and result register.
`include "binary_search_sorted_table_assert.svh"

module bsst_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  bsst_pkg::idx_t         entry_index,
	input  bsst_pkg::data_t        value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output bsst_pkg::idx_t         position,
	input  bsst_pkg::len_t         search_len,
	output bsst_pkg::bsst_ram_req_t ram_req,
	input  bsst_pkg::data_t        ram_rdata
);
	import bsst_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]              state_q;
	logic signed [PTR_W-1:0] lo_q;
	logic signed [PTR_W-1:0] hi_q;
	idx_t                    mid_q;
	data_t                   key_q;
	logic                    res_found_q;
	idx_t                    res_pos_q;
	logic                    out_valid_q;
	logic                    found_q;
	idx_t                    position_q;

	logic                    accept;
	logic                    range_empty;
	logic [IDX_W+1:0]        mid_sum;
	idx_t                    mid;
	logic signed [PTR_W-1:0] mid_ext;
	logic                    out_load;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign range_empty = (lo_q > hi_q);
	// both bounds are non-negative whenever the range is not empty
	assign mid_sum     = {1'b0, lo_q[IDX_W:0]} + {1'b0, hi_q[IDX_W:0]};
	assign mid         = mid_sum[IDX_W:1];
	assign mid_ext     = $signed({2'b00, mid_q});
	assign out_load    = (state_q == ST_WAIT) && (!out_valid_q || out_ready);

	always_comb begin
		ram_req.we    = accept && (mode == MODE_LOAD);
		ram_req.waddr = entry_index;
		ram_req.wdata = value;
		ram_req.re    = (state_q == ST_PROBE) && !range_empty;
		ram_req.raddr = mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_SEARCH)) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					state_q <= range_empty ? ST_WAIT : ST_CMP;
				end
				ST_CMP: begin
					state_q <= (ram_rdata == key_q) ? ST_WAIT : ST_PROBE;
				end
				ST_WAIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search datapath: bounds, probe index, key and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q <= value;
					lo_q  <= '0;
					hi_q  <= $signed({1'b0, search_len}) - PTR_ONE;
				end
			end
			ST_PROBE: begin
				mid_q <= mid;
				if (range_empty) begin
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
				end
			end
			ST_CMP: begin
				if (ram_rdata == key_q) begin
					res_found_q <= 1'b1;
					res_pos_q   <= mid_q;
				end else if (key_q < ram_rdata) begin
					hi_q <= mid_ext - PTR_ONE;
				end else begin
					lo_q <= mid_ext + PTR_ONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

	`BSST_ASSERT_NXT(a_read_then_cmp, ram_req.re, state_q == ST_CMP, "probe read not followed by compare")
	`BSST_ASSERT_IMP(a_mid_in_range, state_q == ST_CMP, (mid_ext >= lo_q) && (mid_ext <= hi_q), "probe index outside search range")
	`BSST_ASSERT_IMP(a_result_from_wait, $rose(out_valid_q), $past(state_q) == ST_WAIT, "result raised outside wait state")
	`BSST_ASSERT_IMP(a_no_write_in_search, state_q != ST_IDLE, !ram_req.we, "table write during a search")

endmodule

// ===== hw/rtl/binary_search_sorted_table.sv =====
// Top level of the binary search block over a sorted table.
// A request with mode 0 writes value into table entry entry_index in the cycle it is
// accepted and gives no result. A request with mode 1 searches entries 0 to
// table_length-1 (table_length above the table depth counts as the full depth) for the
// key in value and gives one result: found and the position of the equal entry, or
// found 0 and position 0. Each probe is a synchronous table read at the midpoint
// followed by the compare and range update. A search that misses after p probes
// needs one more probe step to see the empty range. p is at most
// floor(log2(length))+1, eleven for 1024 entries. The single table memory port in the
// probe loop paces the search, and one search is at work at a time. A finished result
// waits in an output register, so the next request is taken while it is still unread.
// Table entries hold no reset value; search only over written entries. table_length
// is written through the cfg port and resets to 0; the user must see that it is changed
// only while no request is outstanding, which the block itself does not enforce.
module binary_search_sorted_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  bsst_pkg::len_t  cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            mode,
	input  bsst_pkg::idx_t  entry_index,
	input  bsst_pkg::data_t value,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            found,
	output bsst_pkg::idx_t  position
);
	import bsst_pkg::*;

	len_t          table_length_q;
	len_t          search_len;
	bsst_ram_req_t ram_req;
	logic [DATA_W-1:0] ram_rdata;

	// Configuration is a plain register write: always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			table_length_q <= cfg_data;
		end
	end

	// Clamp the length to the table depth.
	assign search_len = (table_length_q > LEN_MAX) ? LEN_MAX : table_length_q;

	bsst_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.entry_index (entry_index),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.position    (position),
		.search_len  (search_len),
		.ram_req     (ram_req),
		.ram_rdata   ($signed(ram_rdata))
	);

	// Table store: written by loads, read once per probe.
	bsst_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the binary search block over a sorted table.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bsst_pkg::*;

	// Longest search is eleven probes plus the final empty-range check; leave some margin on top.
	localparam int SETTLE      = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 15;

	localparam data_t DATA_MIN = 32'sh8000_0000;
	localparam data_t DATA_MAX = 32'sh7fff_ffff;

	// Small sorted table for the directed part: entry 0 is the minimum, so a key
	// below it drives the range under index zero; three equal entries sit in the middle.
	localparam data_t SEED_TABLE [8] = '{-1000, -5, 0, 0, 0, 7, 100, 32'sh7fff_ffff};
	localparam data_t PROBE_KEYS [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -5, 50, 100,
		-1000, 8};

	typedef struct packed {
		logic hit;
		idx_t pos;
	} search_result_t;

	// Mirror of the table and length; predicts the answer of every accepted search.
	class search_scoreboard;
		data_t          store [TABLE_DEPTH];
		len_t           table_length;
		search_result_t expected_hits [$];
		int             errors;

		function new();
			table_length = '0;
			errors       = 0;
			foreach (store[i])
				store[i] = '0;
		endfunction

		function void note_request(logic req_mode, idx_t req_index, data_t req_value);
			int             lo;
			int             hi;
			int             mid;
			int             span;
			search_result_t res;
			if (req_mode == MODE_LOAD) begin
				store[req_index] = req_value;
				return;
			end
			// Clamp an oversize length to the full depth.
			span = (table_length > LEN_MAX) ? TABLE_DEPTH : int'(table_length);
			res  = '0;
			lo   = 0;
			hi   = span - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (store[mid] == req_value) begin
					res.hit = 1'b1;
					res.pos = idx_t'(mid);
					break;
				end
				if (req_value < store[mid])
					hi = mid - 1;
				else
					lo = mid + 1;
			end
			expected_hits.push_back(res);
		endfunction

		function void check_result(logic got_hit, idx_t got_pos);
			search_result_t want;
			if (expected_hits.size() == 0) begin
				$display("%0t: result with no search outstanding: found %0b position %0d",
					$time, got_hit, got_pos);
				errors++;
				return;
			end
			want = expected_hits.pop_front();
			if (got_hit !== want.hit) begin
				$display("%0t: found mismatch: expected %0b actual %0b", $time, want.hit,
					got_hit);
				errors++;
			end
			if (got_pos !== want.pos) begin
				$display("%0t: position mismatch: expected %0d actual %0d", $time, want.pos,
					got_pos);
				errors++;
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  cfg_valid;
	logic  cfg_ready;
	len_t  cfg_data;
	logic  in_valid;
	logic  in_ready;
	logic  mode;
	idx_t  entry_index;
	data_t value;
	logic  out_valid;
	logic  out_ready;
	logic  found;
	idx_t  position;

	search_scoreboard sb;
	bit               quiet = 1'b0;
	int               cycle_count = 0;

	binary_search_sorted_table u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.entry_index (entry_index),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.position    (position)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a run that hangs; the bound is several times the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Check every result at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(found, position);
	end

	// Receiver: stall in random bursts until the quiet tail of the run.
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Present one request at a falling edge and hold it until accepted. Leave valid high
	// on return, so a back-to-back request does not drop it within the same step.
	task automatic send_request(input logic req_mode, input idx_t req_index,
		input data_t req_value);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= req_mode;
		entry_index <= req_index;
		value       <= req_value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(req_mode, req_index, req_value);
		@(negedge clk);
	endtask

	// Hold off new requests until every search has answered, then let a load settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_hits.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Change the table length only while the block is idle.
	task automatic write_length(input len_t new_length);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= new_length;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.table_length = new_length;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int     k;
		int     phase;
		int     pick;
		int     span;
		longint level;
		longint lo_v;
		longint hi_v;
		data_t  key;
		idx_t   slot;
		len_t   phase_len;

		sb          = new();
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		mode        = MODE_LOAD;
		entry_index = '0;
		value       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table: every search must miss.
		write_length('0);
		send_request(MODE_SEARCH, '0, 0);
		send_request(MODE_SEARCH, '1, DATA_MAX);

		// Load the small table, plus the top index with the most negative value.
		send_request(MODE_LOAD, '1, DATA_MIN);
		for (k = 0; k < 8; k++)
			send_request(MODE_LOAD, idx_t'(k), SEED_TABLE[k]);

		// Single entry: hit, then a key below it that pushes the range under zero.
		write_length(len_t'(1));
		send_request(MODE_SEARCH, '0, -1000);
		send_request(MODE_SEARCH, '0, DATA_MIN);

		// Eight entries: extremes, repeated keys, hits and misses.
		write_length(len_t'(8));
		for (k = 0; k < 8; k++)
			send_request(MODE_SEARCH, idx_t'($urandom), PROBE_KEYS[k]);

		// Fill the whole table ascending, with runs of equal values, ending at the maximum.
		level = longint'(DATA_MIN);
		for (k = 0; k < TABLE_DEPTH; k++) begin
			if (k == TABLE_DEPTH - 1)
				level = longint'(DATA_MAX);
			else if ($urandom_range(0, 3) != 0)
				level += $urandom_range(1, 4000000);
			if (level > longint'(DATA_MAX))
				level = longint'(DATA_MAX);
			send_request(MODE_LOAD, idx_t'(k), data_t'(level));
		end

		// Random phases, each under its own length; the early ones take the extremes.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_len = LEN_MAX;
				1: phase_len = '1;
				2: phase_len = LEN_MAX + 1'b1;
				3: phase_len = len_t'(1);
				4: phase_len = '0;
				5: phase_len = LEN_MAX - 1'b1;
				6: phase_len = len_t'(2);
				default: phase_len = len_t'($urandom_range(0, 2047));
			endcase
			if (phase == PHASES - 1)
				quiet = 1'b1;
			write_length(phase_len);
			span = (phase_len > LEN_MAX) ? TABLE_DEPTH : int'(phase_len);

			for (k = 0; k < PHASE_ITEMS; k++) begin
				// Now and then, pause the sender until every result is back.
				if ((phase == 7 && k == PHASE_ITEMS / 2) || $urandom_range(0, 199) == 0)
					drain();
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					slot = idx_t'($urandom_range(0, TABLE_DEPTH - 1));
					if ($urandom_range(0, 19) == 0) begin
						// Noise: an arbitrary value that may break the ordering.
						key = data_t'($urandom);
					end else begin
						// Keep the table sorted: pick a value between the neighbours.
						lo_v = (slot == 0) ? longint'(DATA_MIN) : longint'(sb.store[slot - 1]);
						hi_v = (slot == TABLE_DEPTH - 1) ? longint'(DATA_MAX) :
							longint'(sb.store[slot + 1]);
						if (hi_v < lo_v)
							hi_v = lo_v;
						key = data_t'(lo_v + longint'({$urandom, $urandom} % (hi_v - lo_v + 1)));
					end
					send_request(MODE_LOAD, slot, key);
				end else begin
					// Mostly keys present in range, some just beside one, some arbitrary.
					if (span > 0 && pick < 70)
						key = sb.store[$urandom_range(0, span - 1)];
					else if (span > 0 && pick < 85)
						key = sb.store[$urandom_range(0, span - 1)] + (pick[0] ? 1 : -1);
					else
						key = data_t'($urandom);
					send_request(MODE_SEARCH, idx_t'($urandom), key);
				end
			end
		end

		// Wait for the last answers and any stray result behind them.
		in_valid <= 1'b0;
		while (sb.expected_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bsst_pkg.sv
hw/rtl/bsst_ram.sv
hw/rtl/bsst_ctrl.sv
hw/rtl/binary_search_sorted_table.sv
test/testbench.sv
